FILE: design/bt_lpm_pkg.sv
// ----------------------------------------------------------------------------
// bt_lpm_pkg
// Shared constants and types of the binary trie longest-prefix-match engine.
// ----------------------------------------------------------------------------
package bt_lpm_pkg;

    localparam int ADDR_BITS     = 32;
    localparam int LEN_W         = 6;
    localparam int HOP_W         = 8;
    localparam int NODES_DEFAULT = 4096;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } bt_state_t;

endpackage

FILE: design/binary_trie_prefix_lookup.sv
// ----------------------------------------------------------------------------
// binary_trie_prefix_lookup
// Longest-prefix-match engine on a unibit binary trie held in a node memory.
// ----------------------------------------------------------------------------
// Usage: raise start with operation, address, prefix_len and next_hop_in; the
// item is taken at a clock edge where start is high and busy is low. A lookup
// (operation 0) follows the address bits from the root and returns the hop
// of the deepest node that holds one, with found set. An insert (operation 1)
// follows the top prefix_len bits (above 32 counts as 32), allocates missing
// nodes and stores the hop only if the last node has none yet; table_full is
// set when a node was needed and none was free.
// The address sits in a shift register that moves up one bit per trie level,
// and each level issues one node-memory read (registered) and at most one
// write. The next item may be accepted in the cycle of the done strobe.
// Each result is shown for one cycle with done high; the receiver cannot
// stall. Reset clears the root node and sets the node count to one; no
// clearing pass runs, since every node is cleared when it is allocated.
// ----------------------------------------------------------------------------
module binary_trie_prefix_lookup
    import bt_lpm_pkg::*;
#(
    parameter int NODES = NODES_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             operation,
    input  logic [31:0]      address,
    input  logic [5:0]       prefix_len,
    input  logic [7:0]       next_hop_in,
    output logic             done,
    output logic             found,
    output logic [7:0]       next_hop_out,
    output logic             table_full
);

    localparam int IDX_W = $clog2(NODES);
    localparam int CNT_W = $clog2(NODES) + 1;
    localparam logic [CNT_W-1:0] NODES_C = CNT_W'(NODES);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_BITS);

    typedef struct packed {
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic             valid;
        logic [HOP_W-1:0] hop;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    bt_state_t             state_reg, state_next;
    logic                  op_reg, op_next;
    logic [ADDR_BITS-1:0]  addr_reg, addr_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [LEN_W-1:0]      depth_reg, depth_next;
    logic [HOP_W-1:0]      hop_in_reg, hop_in_next;
    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic                  fresh_reg, fresh_next;
    logic [CNT_W-1:0]      used_reg, used_next;
    node_t                 root_reg, root_next;
    logic                  best_reg, best_next;
    logic [HOP_W-1:0]      best_hop_reg, best_hop_next;
    logic                  done_reg, done_next;
    logic                  found_reg, found_next;
    logic [HOP_W-1:0]      hop_out_reg, hop_out_next;
    logic                  full_reg, full_next;

    node_t                 nd;
    node_t                 wr_node;
    logic                  wr_any;
    logic                  mem_we;
    logic [IDX_W-1:0]      rd_addr;
    logic [NODE_W-1:0]     rd_data;
    logic                  bit_now;
    logic [IDX_W-1:0]      child;
    logic [IDX_W-1:0]      new_idx;

    bt_lpm_node_ram #(
        .DEPTH  (NODES),
        .ADDR_W (IDX_W),
        .DATA_W (NODE_W)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (cur_reg),
        .wr_data (wr_node),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= CNT_W'(1);
            root_reg  <= '0;
            done_reg  <= 1'b0;
            fresh_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            root_reg  <= root_next;
            done_reg  <= done_next;
            fresh_reg <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        len_reg      <= len_next;
        depth_reg    <= depth_next;
        hop_in_reg   <= hop_in_next;
        cur_reg      <= cur_next;
        best_reg     <= best_next;
        best_hop_reg <= best_hop_next;
        found_reg    <= found_next;
        hop_out_reg  <= hop_out_next;
        full_reg     <= full_next;
    end

    // The current node comes from the root registers, from the memory read
    // issued last cycle, or is all zero when it was just allocated.
    always_comb
    begin
        if (cur_reg == '0)
        begin
            nd = root_reg;
        end
        else if (fresh_reg)
        begin
            nd = '0;
        end
        else
        begin
            nd = node_t'(rd_data);
        end
    end

    assign bit_now = addr_reg[ADDR_BITS-1];
    assign child   = bit_now ? nd.hi : nd.lo;
    assign new_idx = used_reg[IDX_W-1:0];
    assign mem_we  = wr_any && (cur_reg != '0);

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        addr_next     = addr_reg;
        len_next      = len_reg;
        depth_next    = depth_reg;
        hop_in_next   = hop_in_reg;
        cur_next      = cur_reg;
        fresh_next    = fresh_reg;
        used_next     = used_reg;
        root_next     = root_reg;
        best_next     = best_reg;
        best_hop_next = best_hop_reg;
        done_next     = 1'b0;
        found_next    = found_reg;
        hop_out_next  = hop_out_reg;
        full_next     = full_reg;
        wr_any        = 1'b0;
        wr_node       = nd;
        rd_addr       = child;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next    = S_WALK;
                    op_next       = operation;
                    addr_next     = address;
                    len_next      = (prefix_len > MAX_LEN) ? MAX_LEN : prefix_len;
                    hop_in_next   = next_hop_in;
                    depth_next    = '0;
                    cur_next      = '0;
                    fresh_next    = 1'b0;
                    best_next     = 1'b0;
                    best_hop_next = '0;
                end
            end

            S_WALK:
            begin
                if (op_reg == OP_LOOKUP)
                begin
                    if (nd.valid)
                    begin
                        best_next     = 1'b1;
                        best_hop_next = nd.hop;
                    end
                    if (depth_reg == MAX_LEN || child == '0)
                    begin
                        state_next   = S_IDLE;
                        done_next    = 1'b1;
                        found_next   = nd.valid | best_reg;
                        hop_out_next = nd.valid ? nd.hop : best_hop_reg;
                        full_next    = 1'b0;
                    end
                    else
                    begin
                        cur_next   = child;
                        depth_next = depth_reg + LEN_W'(1);
                        addr_next  = addr_reg << 1;
                    end
                end
                else
                begin
                    if (depth_reg == len_reg)
                    begin
                        // First insert of a prefix wins.
                        if (!nd.valid)
                        begin
                            wr_any        = 1'b1;
                            wr_node.valid = 1'b1;
                            wr_node.hop   = hop_in_reg;
                        end
                        state_next   = S_IDLE;
                        done_next    = 1'b1;
                        found_next   = 1'b0;
                        hop_out_next = '0;
                        full_next    = 1'b0;
                    end
                    else if (child != '0)
                    begin
                        cur_next   = child;
                        fresh_next = 1'b0;
                        depth_next = depth_reg + LEN_W'(1);
                        addr_next  = addr_reg << 1;
                    end
                    else if (used_reg >= NODES_C)
                    begin
                        // A node allocated last step was never stored: clear it.
                        if (fresh_reg)
                        begin
                            wr_any  = 1'b1;
                            wr_node = '0;
                        end
                        state_next   = S_IDLE;
                        done_next    = 1'b1;
                        found_next   = 1'b0;
                        hop_out_next = '0;
                        full_next    = 1'b1;
                    end
                    else
                    begin
                        wr_any = 1'b1;
                        if (bit_now)
                        begin
                            wr_node.hi = new_idx;
                        end
                        else
                        begin
                            wr_node.lo = new_idx;
                        end
                        cur_next   = new_idx;
                        fresh_next = 1'b1;
                        used_next  = used_reg + CNT_W'(1);
                        depth_next = depth_reg + LEN_W'(1);
                        addr_next  = addr_reg << 1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (wr_any && cur_reg == '0)
        begin
            root_next = wr_node;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign found        = found_reg;
    assign next_hop_out = hop_out_reg;
    assign table_full   = full_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= NODES_C && used_reg != '0)
        else $error("node count out of range");

    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(found && table_full) && (found || next_hop_out == '0))
        else $error("inconsistent result item");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy && !done)
        else $error("accepted item did not start a walk");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> depth_reg <= MAX_LEN && (op_reg == OP_LOOKUP || depth_reg <= len_reg))
        else $error("walk went past its last level");

endmodule

FILE: design/bt_lpm_node_ram.sv
// ----------------------------------------------------------------------------
// bt_lpm_node_ram
// Node memory of the trie: one write port and one read port with a
// registered read. Entries are undefined until written.
// ----------------------------------------------------------------------------
module bt_lpm_node_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 33
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
